/* rtl/modified_utf8_byte_sanitizer_unit_defines.svh */
// Assertion macros shared by the sanitizer RTL.
`ifndef MODIFIED_UTF8_BYTE_SANITIZER_UNIT_DEFINES_SVH
`define MODIFIED_UTF8_BYTE_SANITIZER_UNIT_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MUS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MUS_ASSERT(lbl, prop, msg) `MUS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/mus_pkg.sv */
`default_nettype none

package mus_pkg;

  // Default depth of the bundle queue between front and back.
  localparam int unsigned FifoDepthDef = 4;

  // Most result bytes that one input item can cause.
  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] QMark    = 8'h3F;
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContBits = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  typedef logic [1:0] res_cnt_t;

  // All result bytes caused by one input item, oldest in entry 0.
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    res_cnt_t               count;
    logic                   str_last;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // What is held while a multi-byte sequence is incomplete.
  typedef enum logic [3:0] {
    PendNone   = 4'b0001,
    PendTwo    = 4'b0010,
    PendThree  = 4'b0100,
    PendThree2 = 4'b1000
  } pend_e;

  typedef enum logic [1:0] {
    ClsAscii = 2'd0,
    ClsLead2 = 2'd1,
    ClsLead3 = 2'd2,
    ClsBad   = 2'd3
  } byte_cls_e;

  // Classify a byte seen with nothing pending.
  function automatic byte_cls_e classify(logic [7:0] b);
    byte_cls_e cls;
    unique case (b[7:4]) inside
      [4'h0:4'h7]: cls = ClsAscii;
      4'hC, 4'hD:  cls = ClsLead2;
      4'hE:        cls = ClsLead3;
      default:     cls = ClsBad;
    endcase
    return cls;
  endfunction

  function automatic logic is_cont(logic [7:0] b);
    return (b & ContMask) == ContBits;
  endfunction

endpackage

`default_nettype wire

/* rtl/mus_front.sv */
`default_nettype none

module mus_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire mus_pkg::in_item_t   in_item_i,
  input  wire mus_pkg::fifo_stat_t fifo_stat_i,
  output logic                     push_o,
  output mus_pkg::bundle_t         bundle_o,
  output logic                     pend_idle_o
);

  mus_pkg::pend_e     pend_q, pend_d;
  logic [7:0]         lead_q, lead_d;
  logic [7:0]         second_q, second_d;
  logic               accept;
  logic [7:0]         b;
  logic               cont;
  logic               do_fresh;
  mus_pkg::res_cnt_t  cnt;
  mus_pkg::res_cnt_t  flush;
  logic [2:0]         total;
  mus_pkg::byte_cls_e cls;

  assign in_ready_o  = !fifo_stat_i.full;
  assign accept      = in_valid_i && in_ready_o;
  assign b           = in_item_i.in_byte;
  assign cont        = mus_pkg::is_cont(b);
  assign cls         = mus_pkg::classify(b);
  assign pend_idle_o = (pend_q == mus_pkg::PendNone);

  // Build the result bundle and the next held state for this byte.
  always_comb begin
    pend_d   = pend_q;
    lead_d   = lead_q;
    second_d = second_q;
    do_fresh = 1'b0;
    cnt      = '0;
    bundle_o.bytes = {mus_pkg::MaxRes{mus_pkg::QMark}};

    // Resolve whatever is pending
    unique case (pend_q)
      mus_pkg::PendNone: begin
        do_fresh = 1'b1;
      end
      mus_pkg::PendTwo: begin
        pend_d = mus_pkg::PendNone;
        if (cont) begin
          bundle_o.bytes[0] = lead_q;
          bundle_o.bytes[1] = b;
          cnt = 2'd2;
        end else begin
          cnt      = 2'd1;
          do_fresh = 1'b1;
        end
      end
      mus_pkg::PendThree: begin
        if (cont) begin
          second_d = b;
          pend_d   = mus_pkg::PendThree2;
        end else begin
          pend_d   = mus_pkg::PendNone;
          cnt      = 2'd1;
          do_fresh = 1'b1;
        end
      end
      mus_pkg::PendThree2: begin
        pend_d = mus_pkg::PendNone;
        if (cont) begin
          bundle_o.bytes[0] = lead_q;
          bundle_o.bytes[1] = second_q;
          bundle_o.bytes[2] = b;
          cnt = 2'd3;
        end else begin
          cnt      = 2'd2;
          do_fresh = 1'b1;
        end
      end
      default: begin
        pend_d   = mus_pkg::PendNone;
        do_fresh = 1'b1;
      end
    endcase

    // Examine the byte afresh: pass, replace or hold as a lead
    if (do_fresh) begin
      unique case (cls)
        mus_pkg::ClsAscii: begin
          bundle_o.bytes[cnt] = b;
          cnt = cnt + 2'd1;
        end
        mus_pkg::ClsLead2: begin
          lead_d = b;
          pend_d = mus_pkg::PendTwo;
        end
        mus_pkg::ClsLead3: begin
          lead_d = b;
          pend_d = mus_pkg::PendThree;
        end
        default: begin
          cnt = cnt + 2'd1;
        end
      endcase
    end

    // Flush held bytes as '?' at string end, capped at the bundle size
    flush = '0;
    if (in_item_i.string_last) begin
      if (pend_d == mus_pkg::PendTwo || pend_d == mus_pkg::PendThree) begin
        flush = 2'd1;
      end else if (pend_d == mus_pkg::PendThree2) begin
        flush = 2'd2;
      end
      pend_d = mus_pkg::PendNone;
    end
    total = {1'b0, cnt} + {1'b0, flush};
    bundle_o.count    = (total > 3'(mus_pkg::MaxRes)) ? 2'(mus_pkg::MaxRes) : total[1:0];
    bundle_o.str_last = in_item_i.string_last;
  end

  assign push_o = accept && (bundle_o.count != '0);

  // Advance the pending state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= mus_pkg::PendNone;
    end else if (accept) begin
      pend_q <= pend_d;
    end
  end

  // Hold the lead and first continuation
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lead_q   <= lead_d;
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/mus_fifo.sv */
`default_nettype none

module mus_fifo #(
  parameter int unsigned Depth = mus_pkg::FifoDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mus_pkg::bundle_t data_i,
  input  wire logic             pop_i,
  output mus_pkg::bundle_t      data_o,
  output mus_pkg::fifo_stat_t   stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mus_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the incoming bundle
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/mus_back.sv */
`default_nettype none

module mus_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mus_pkg::bundle_t    data_i,
  input  wire mus_pkg::fifo_stat_t fifo_stat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mus_pkg::out_item_t       out_item_o
);

  mus_pkg::res_cnt_t  idx_q;
  logic               out_valid_q;
  mus_pkg::out_item_t out_q, out_d;
  logic               load;
  logic               final_byte;

  assign load       = !fifo_stat_i.empty && (!out_valid_q || out_ready_i);
  assign final_byte = (idx_q == data_i.count - 2'd1);
  assign pop_o      = load && final_byte;

  // Pick the next byte of the head bundle
  always_comb begin
    out_d.out_byte   = data_i.bytes[idx_q];
    out_d.run_last   = final_byte;
    out_d.string_end = final_byte && data_i.str_last;
  end

  // Advance the byte index and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= final_byte ? '0 : idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* rtl/modified_utf8_byte_sanitizer_unit.sv */
// Modified UTF-8 byte sanitizer.
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one raw byte per item,
// with string_last set on the final byte of a string. Output channel
// (out_valid_o/out_ready_i/out_item_o) gives one corrected byte per item;
// run_last marks the last byte caused by an input item, string_end the
// last byte of a string. Invalid sequences are replaced by '?'.
// An input's bundle enters the queue at the edge that accepts the input, and
// its first byte loads into the output register once that register is empty
// or its byte is taken, so that byte is offered from then on.
// Throughput: one input per cycle while the bundle queue has room; the
// output drains one byte per cycle while out_ready_i is high. An input
// causes zero to three bytes; over a string as many bytes leave as enter,
// so the sustained rate is one byte per cycle, set by the single-byte output register.
// Reset clears the pending sequence state, the queue and the output valid.
// When the receiver stalls, the output item holds, the queue fills, and
// in_ready_o falls once FifoDepth bundles wait.
`default_nettype none
`include "modified_utf8_byte_sanitizer_unit_defines.svh"

module modified_utf8_byte_sanitizer_unit #(
  parameter int unsigned FifoDepth = mus_pkg::FifoDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mus_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mus_pkg::out_item_t     out_item_o
);

  mus_pkg::fifo_stat_t fifo_stat;
  mus_pkg::bundle_t    push_bundle;
  mus_pkg::bundle_t    head_bundle;
  logic                push;
  logic                pop;
  logic                pend_idle;

  // Classify bytes and build result bundles
  mus_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .bundle_o    (push_bundle),
    .pend_idle_o (pend_idle)
  );

  // Decouple front and back
  mus_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_bundle),
    .pop_i  (pop),
    .data_o (head_bundle),
    .stat_o (fifo_stat)
  );

  // Serialise bundles into output bytes
  mus_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_i      (head_bundle),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `MUS_ASSERT(a_end_is_run_last, out_valid_o && out_item_o.string_end |-> out_item_o.run_last, "string_end without run_last")
  `MUS_ASSERT(a_flush_at_end, in_valid_i && in_ready_o && in_item_i.string_last |=> pend_idle, "bytes still held after string end")
  `MUS_ASSERT(a_no_phantom, !out_valid_o && fifo_stat.empty && !(in_valid_i && in_ready_o) |=> !out_valid_o, "output item from empty block")
  `MUS_ASSERT(a_fifo_flags, !(fifo_stat.full && fifo_stat.empty), "queue both full and empty")

endmodule

`default_nettype wire
